// ===== hw/rtl/met_pkg.sv =====
`timescale 1ns / 1ps

package met_pkg;

    localparam int CHANNELS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int PIN_BITS   = 16;
    localparam int CHANNEL_W  = 4;
    localparam int INTERVAL_W = 32;

    // Only channels that have a pin can ever see an edge.
    localparam int SCAN_CH = (CHANNELS < PIN_BITS) ? CHANNELS : PIN_BITS;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [PIN_BITS-1:0] MASK_RESET = 16'hA000;

    typedef struct packed {
        logic [CHANNEL_W-1:0]  channel;
        logic [INTERVAL_W-1:0] interval;
        logic                  last;
    } met_result_t;

endpackage

// ===== hw/rtl/met_if.sv =====
`timescale 1ns / 1ps

interface met_in_if;
    logic                         valid;
    logic                         ready;
    logic [met_pkg::PIN_BITS-1:0] pin_sample;

    modport source (output valid, output pin_sample, input ready);
    modport sink (input valid, input pin_sample, output ready);
endinterface

interface met_out_if;
    logic                           valid;
    logic                           ready;
    logic [met_pkg::CHANNEL_W-1:0]  channel;
    logic [met_pkg::INTERVAL_W-1:0] interval;
    logic                           last;

    modport source (output valid, output channel, output interval, output last, input ready);
    modport sink (input valid, input channel, input interval, input last, output ready);
endinterface

// ===== hw/rtl/met_edge_scan.sv =====
`timescale 1ns / 1ps

module met_edge_scan
(
    input  logic                         clk,
    input  logic                         rst_n,
    met_in_if.sink                       tick,
    input  logic [met_pkg::PIN_BITS-1:0] report_mask,
    output logic                         res_valid,
    output met_pkg::met_result_t         res,
    input  logic                         res_ready
);

    logic [met_pkg::TIME_BITS-1:0] ts_mem [met_pkg::CHANNELS];
    logic [met_pkg::CHANNELS-1:0]  ts_valid_reg;

    logic [met_pkg::TIME_BITS-1:0] tick_count_reg;
    logic [met_pkg::TIME_BITS-1:0] tick_count_next;
    logic [met_pkg::PIN_BITS-1:0]  prev_reg;
    logic [met_pkg::SCAN_CH-1:0]   pending_reg;
    logic [met_pkg::SCAN_CH-1:0]   pending_next;
    logic [met_pkg::SCAN_CH-1:0]   rising_reg;
    logic [met_pkg::SCAN_CH-1:0]   rising_next;

    logic                          s_valid_reg;
    logic [met_pkg::CH_W-1:0]      s_ch_reg;
    logic [met_pkg::TIME_BITS-1:0] ts_rdata_reg;
    logic                          ts_rvalid_reg;

    logic                          idle;
    logic                          accept;
    logic                          s_emit;
    logic                          s_done;
    logic                          advance;
    logic                          rd_en;
    logic [met_pkg::CH_W-1:0]      rd_addr;
    logic [met_pkg::TIME_BITS-1:0] old_ts;
    logic [met_pkg::TIME_BITS-1:0] diff;
    logic [met_pkg::SCAN_CH-1:0]   above;

    assign idle       = (pending_reg == '0) && !s_valid_reg;
    assign tick.ready = idle;
    assign accept     = tick.valid && idle;

    assign tick_count_next = tick_count_reg + met_pkg::TIME_BITS'(1);
    assign rising_next     = met_pkg::SCAN_CH'(tick.pin_sample & ~prev_reg);

    // The lowest pending channel is read next.
    always_comb
    begin
        rd_addr = '0;
        for (int i = met_pkg::SCAN_CH - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                rd_addr = met_pkg::CH_W'(i);
            end
        end
    end

    assign s_emit  = s_valid_reg && report_mask[s_ch_reg];
    assign s_done  = s_valid_reg && (!s_emit || res_ready);
    assign advance = !s_valid_reg || s_done;
    assign rd_en   = advance && (pending_reg != '0);

    always_comb
    begin
        pending_next = pending_reg;
        if (accept)
        begin
            pending_next = rising_next;
        end
        else if (rd_en)
        begin
            pending_next[rd_addr] = 1'b0;
        end
    end

    // A timestamp that was never written reads as zero.
    assign old_ts = ts_rvalid_reg ? ts_rdata_reg : '0;
    assign diff   = (tick_count_reg > old_ts) ? (tick_count_reg - old_ts)
                                              : (old_ts - tick_count_reg);

    always_comb
    begin
        for (int i = 0; i < met_pkg::SCAN_CH; i++)
        begin
            above[i] = (i > int'(s_ch_reg));
        end
    end

    assign res_valid    = s_emit;
    assign res.channel  = met_pkg::CHANNEL_W'(s_ch_reg);
    assign res.interval = met_pkg::INTERVAL_W'(diff);
    assign res.last     = ((rising_reg & met_pkg::SCAN_CH'(report_mask) & above) == '0);

    // Channels within one tick are distinct, and a new tick starts only after all
    // write-backs of the previous one, so a read never overlaps a pending write.
    always_ff @(posedge clk)
    begin
        if (s_done)
        begin
            ts_mem[s_ch_reg] <= tick_count_reg;
        end
        if (rd_en)
        begin
            ts_rdata_reg <= ts_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            prev_reg       <= '0;
            pending_reg    <= '0;
            rising_reg     <= '0;
            s_valid_reg    <= 1'b0;
            s_ch_reg       <= '0;
            ts_valid_reg   <= '0;
            ts_rvalid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (accept)
            begin
                tick_count_reg <= tick_count_next;
                prev_reg       <= tick.pin_sample;
                rising_reg     <= rising_next;
            end
            if (advance)
            begin
                s_valid_reg <= rd_en;
            end
            if (rd_en)
            begin
                s_ch_reg      <= rd_addr;
                ts_rvalid_reg <= ts_valid_reg[rd_addr];
            end
            if (s_done)
            begin
                ts_valid_reg[s_ch_reg] <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/met_out_stage.sv =====
`timescale 1ns / 1ps

module met_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  met_pkg::met_result_t res,
    output logic                 res_ready,
    met_out_if.source            result
);

    logic                 out_valid_reg;
    met_pkg::met_result_t out_data_reg;

    assign res_ready       = !out_valid_reg || result.ready;
    assign result.valid    = out_valid_reg;
    assign result.channel  = out_data_reg.channel;
    assign result.interval = out_data_reg.interval;
    assign result.last     = out_data_reg.last;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

endmodule

// ===== hw/rtl/multichannel_edge_interval_timer.sv =====
`timescale 1ns / 1ps

// Multichannel edge interval timer.
// The tick channel takes one item per timer tick, carrying the sixteen pin levels.
// Each tick advances a 32-bit tick count; every channel with a rising edge has its
// interval since its previous rising edge measured and its timestamp updated.
// The result channel carries (channel, interval, last) for every rising edge whose
// channel is enabled in the report mask, in ascending channel order; last marks
// the final result of a tick. A tick with no reported edge yields no result.
// The report mask is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce this itself.
// A tick, its edges reported or not, occupies the block from the cycle that takes
// it through one timestamp read per edge to the final write-back.
// Each reported edge passes the pending, timestamp read and output registers.
// The timestamp memory has a single read and a single write port, which sets the
// rate of one edge per cycle while the output register does not stall the scan.
// When the receiver stalls, the output register holds its result and the scan
// waits; the next tick is refused until the current one is finished.
// Reset clears the tick count and previous sample and marks all timestamps as
// unwritten, which read as zero; the report mask is set to channels 13 and 15.

module multichannel_edge_interval_timer
(
    input  logic                         clk,
    input  logic                         rst_n,
    met_in_if.sink                       tick,
    met_out_if.source                    result,
    input  logic                         cfg_we,
    input  logic [met_pkg::PIN_BITS-1:0] cfg_wdata
);

    logic [met_pkg::PIN_BITS-1:0] mask_reg;
    logic                         res_valid;
    logic                         res_ready;
    met_pkg::met_result_t         res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= met_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    met_edge_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .report_mask (mask_reg),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    met_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .result    (result)
    );

    // A result waiting for the output register stays the same.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("scan result changed while stalled");

    // No result is produced while the block is ready for a new tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick.ready |-> !res_valid)
    else $error("result produced while idle");

    // A result taken into the output register appears on the result channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (result.valid && result.channel == $past(res.channel)))
    else $error("output register lost a result");

endmodule

// ===== sim/multichannel_edge_interval_timer_test.sv =====
`timescale 1ns / 1ps

module multichannel_edge_interval_timer_test;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_TICKS   = 56;
    localparam int PHASE_COUNT   = 8;
    localparam int CYCLE_LIMIT   = 500000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [met_pkg::PIN_BITS-1:0] cfg_wdata;

    met_in_if  tick_if ();
    met_out_if res_if ();

    multichannel_edge_interval_timer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow state of the timer.
    logic [met_pkg::TIME_BITS-1:0] shadow_ticks;
    logic [met_pkg::PIN_BITS-1:0]  shadow_prev_pins;
    logic [met_pkg::TIME_BITS-1:0] shadow_stamps [met_pkg::CHANNELS];
    logic [met_pkg::PIN_BITS-1:0]  shadow_mask;

    logic [met_pkg::PIN_BITS-1:0] tick_queue [$];
    met_pkg::met_result_t         pending_intervals [$];
    met_pkg::met_result_t         expected_item;
    logic [met_pkg::PIN_BITS-1:0] last_sample;

    bit          tick_hold;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          ticks_sent;
    int          intervals_checked;
    int          mask_writes;
    int          pauses_done;
    int unsigned cycle_count;

    // Advance the shadow timer by one tick and queue the intervals it reports.
    function automatic void predict_intervals(input logic [met_pkg::PIN_BITS-1:0] pins);
        logic [met_pkg::PIN_BITS-1:0]  rising;
        logic [met_pkg::TIME_BITS-1:0] old_stamp;
        logic [met_pkg::TIME_BITS-1:0] diff;
        met_pkg::met_result_t          item;
        int                            first_new;
        first_new = pending_intervals.size();
        shadow_ticks = shadow_ticks + met_pkg::TIME_BITS'(1);
        rising = pins & ~shadow_prev_pins;
        for (int ch = 0; ch < met_pkg::SCAN_CH; ch++)
        begin
            if (rising[ch])
            begin
                old_stamp = shadow_stamps[ch];
                diff = (shadow_ticks > old_stamp) ? shadow_ticks - old_stamp
                                                  : old_stamp - shadow_ticks;
                shadow_stamps[ch] = shadow_ticks;
                if (shadow_mask[ch])
                begin
                    item.channel  = met_pkg::CHANNEL_W'(ch);
                    item.interval = diff[met_pkg::INTERVAL_W-1:0];
                    item.last     = 1'b0;
                    pending_intervals.push_back(item);
                end
            end
        end
        if (pending_intervals.size() > first_new)
            pending_intervals[pending_intervals.size()-1].last = 1'b1;
        shadow_prev_pins = pins;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [met_pkg::PIN_BITS-1:0] next_pin_sample(
        input logic [met_pkg::PIN_BITS-1:0] prev);
        logic [met_pkg::PIN_BITS-1:0] s;
        case ($urandom_range(4))
            0: s = met_pkg::PIN_BITS'($urandom);
            1: s = prev ^ (met_pkg::PIN_BITS'(1) << $urandom_range(met_pkg::PIN_BITS-1));
            2: s = prev ^ met_pkg::PIN_BITS'($urandom & $urandom);
            3: s = ~prev;
            default: s = prev | met_pkg::PIN_BITS'($urandom);
        endcase
        return s;
    endfunction

    // Wait until every tick is taken and every interval has come out, then let
    // the block finish any tick that reports nothing.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || tick_if.valid || pending_intervals.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [met_pkg::PIN_BITS-1:0] mask);
        cfg_we      <= 1'b1;
        cfg_wdata   <= mask;
        shadow_mask = mask;
        mask_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int count, input bit pause_midway);
        for (int n = 0; n < count; n++)
        begin
            last_sample = next_pin_sample(last_sample);
            tick_queue.push_back(last_sample);
        end
        if (pause_midway)
        begin
            do
                @(posedge clk);
            while (tick_queue.size() > count / 2);
            tick_hold <= 1'b1;
            do
                @(posedge clk);
            while (tick_if.valid || pending_intervals.size() != 0);
            tick_hold <= 1'b0;
            pauses_done++;
        end
        wait_idle();
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        tick_if.valid     = 1'b0;
        tick_if.pin_sample = '0;
        res_if.ready      = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Tick driver: a presented item is held until the block takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
            tick_if.valid <= 1'b0;
        else
        begin
            if (tick_if.valid && tick_if.ready)
            begin
                predict_intervals(tick_if.pin_sample);
                ticks_sent++;
            end
            if (tick_if.valid && !tick_if.ready)
                tick_if.valid <= 1'b1;
            else if (tick_queue.size() != 0 && !tick_hold
                     && $urandom_range(99) >= send_idle_pct)
            begin
                tick_if.valid      <= 1'b1;
                tick_if.pin_sample <= tick_queue.pop_front();
            end
            else
                tick_if.valid <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (pending_intervals.size() == 0)
                begin
                    $error("unexpected result: channel %0d interval %0d last %0d",
                           res_if.channel, res_if.interval, res_if.last);
                    error_count++;
                end
                else
                begin
                    expected_item = pending_intervals.pop_front();
                    compare_field("channel", expected_item.channel, res_if.channel);
                    compare_field("interval", expected_item.interval, res_if.interval);
                    compare_field("last", expected_item.last, res_if.last);
                    intervals_checked++;
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    logic [met_pkg::PIN_BITS-1:0] masked_ticks [$] = '{16'h0000, 16'hFFFF, 16'h0000,
                                                       16'hA000, 16'h5FFF, 16'h0000,
                                                       16'h2000, 16'h8000};
    logic [met_pkg::PIN_BITS-1:0] full_ticks [$]   = '{16'hFFFF, 16'h0000, 16'hFFFF,
                                                       16'h5555, 16'hAAAA, 16'h0001,
                                                       16'h0000, 16'h8000, 16'h0000};
    logic [met_pkg::PIN_BITS-1:0] silent_ticks [$] = '{16'hFFFF, 16'h0000, 16'h0F0F};

    initial
    begin
        logic [met_pkg::PIN_BITS-1:0] phase_masks [PHASE_COUNT];
        shadow_ticks     = '0;
        shadow_prev_pins = '0;
        shadow_mask      = met_pkg::MASK_RESET;
        foreach (shadow_stamps[i])
            shadow_stamps[i] = '0;
        last_sample   = '0;
        tick_hold     = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 75;
        phase_masks   = '{16'hFFFF, 16'(($urandom)), 16'h0001, 16'h8000,
                          16'h0000, 16'(($urandom)), 16'hA000, 16'hFFFF};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the reset mask, then every channel, then nothing reported.
        foreach (masked_ticks[i])
            tick_queue.push_back(masked_ticks[i]);
        wait_idle();
        write_mask(16'hFFFF);
        foreach (full_ticks[i])
            tick_queue.push_back(full_ticks[i]);
        wait_idle();
        write_mask(16'h0000);
        foreach (silent_ticks[i])
            tick_queue.push_back(silent_ticks[i]);
        wait_idle();
        last_sample = silent_ticks[silent_ticks.size()-1];

        for (int k = 0; k < PHASE_COUNT; k++)
        begin
            if (k < 3)
            begin
                send_idle_pct <= 24;
                recv_idle_pct <= 75;
            end
            else if (k < 6)
            begin
                send_idle_pct <= 75;
                recv_idle_pct <= 24;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            write_mask(phase_masks[k]);
            run_random_phase(PHASE_TICKS, k == 1 || k == 4);
        end

        $display("Run covered %0d ticks and %0d checked intervals over %0d mask writes,",
                 ticks_sent, intervals_checked, mask_writes);
        $display("with %0d full drains while ticks were held back.", pauses_done);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
